/* hdl/mer_pkg.sv */
package mer_pkg;

  localparam int AXIS_BITS_DEF = 10;
  localparam int PC_BITS = 4;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PR_START,
    PR_CMP,
    PR_R1_NEG,
    PR_R1_POS,
    PR_R2_INIT,
    PR_R2_NEG,
    PR_R2_POS
  } prog_t;

  typedef enum logic [2:0] {
    OP_AX,
    OP_X,
    OP_Y,
    OP_ASQ,
    OP_BSQ,
    OP_SQ,
    OP_ONE,
    OP_TWELVE
  } opsel_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_ASQ,
    CAP_BSQ,
    CAP_SQ
  } cap_t;

  typedef struct packed {
    opsel_t     sel_a;
    opsel_t     sel_b;
    logic [1:0] shift;
    logic       sub;
    logic       acc_en;
    cap_t       cap;
    logic       last;
  } uop_t;

  function automatic uop_t mk(opsel_t a, opsel_t b, logic [1:0] sh, logic sub,
                              logic en, cap_t cap, logic last);
    uop_t u;
    u.sel_a  = a;
    u.sel_b  = b;
    u.shift  = sh;
    u.sub    = sub;
    u.acc_en = en;
    u.cap    = cap;
    u.last   = last;
    return u;
  endfunction

  // Each entry is one multiply followed, when acc_en is set, by acc +/- (product << shift).
  function automatic uop_t uop_rom(prog_t prog, logic [PC_BITS-1:0] pc);
    uop_t u;
    u = mk(OP_ONE, OP_ONE, 2'd0, 1'b0, 1'b0, CAP_NONE, 1'b1);
    case (prog)
      PR_START: begin
        case (pc)
          4'd0:    u = mk(OP_AX,  OP_AX, 2'd0, 1'b0, 1'b1, CAP_ASQ,  1'b0);
          4'd1:    u = mk(OP_Y,   OP_Y,  2'd2, 1'b0, 1'b1, CAP_BSQ,  1'b0);
          4'd2:    u = mk(OP_ASQ, OP_Y,  2'd2, 1'b1, 1'b1, CAP_NONE, 1'b1);
          default: ;
        endcase
      end
      PR_CMP: begin
        case (pc)
          4'd0:    u = mk(OP_ASQ, OP_Y, 2'd0, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd1:    u = mk(OP_BSQ, OP_X, 2'd0, 1'b1, 1'b1, CAP_NONE, 1'b1);
          default: ;
        endcase
      end
      PR_R1_NEG: begin
        case (pc)
          4'd0:    u = mk(OP_BSQ, OP_X,      2'd3, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd1:    u = mk(OP_BSQ, OP_TWELVE, 2'd0, 1'b0, 1'b1, CAP_NONE, 1'b1);
          default: ;
        endcase
      end
      PR_R1_POS: begin
        case (pc)
          4'd0:    u = mk(OP_BSQ, OP_X,      2'd3, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd1:    u = mk(OP_ASQ, OP_Y,      2'd3, 1'b1, 1'b1, CAP_NONE, 1'b0);
          4'd2:    u = mk(OP_ASQ, OP_ONE,    2'd3, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd3:    u = mk(OP_BSQ, OP_TWELVE, 2'd0, 1'b0, 1'b1, CAP_NONE, 1'b1);
          default: ;
        endcase
      end
      PR_R2_INIT: begin
        case (pc)
          4'd0:    u = mk(OP_X,   OP_X,   2'd0, 1'b0, 1'b0, CAP_SQ,   1'b0);
          4'd1:    u = mk(OP_BSQ, OP_SQ,  2'd2, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd2:    u = mk(OP_BSQ, OP_X,   2'd2, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd3:    u = mk(OP_Y,   OP_Y,   2'd0, 1'b0, 1'b0, CAP_SQ,   1'b0);
          4'd4:    u = mk(OP_ASQ, OP_SQ,  2'd2, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd5:    u = mk(OP_ASQ, OP_Y,   2'd3, 1'b1, 1'b1, CAP_NONE, 1'b0);
          4'd6:    u = mk(OP_ASQ, OP_ONE, 2'd2, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd7:    u = mk(OP_BSQ, OP_ONE, 2'd0, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd8:    u = mk(OP_ASQ, OP_BSQ, 2'd2, 1'b1, 1'b1, CAP_NONE, 1'b1);
          default: ;
        endcase
      end
      PR_R2_NEG: begin
        case (pc)
          4'd0:    u = mk(OP_BSQ, OP_X,      2'd3, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd1:    u = mk(OP_ASQ, OP_Y,      2'd3, 1'b1, 1'b1, CAP_NONE, 1'b0);
          4'd2:    u = mk(OP_ASQ, OP_TWELVE, 2'd0, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd3:    u = mk(OP_BSQ, OP_ONE,    2'd3, 1'b0, 1'b1, CAP_NONE, 1'b1);
          default: ;
        endcase
      end
      PR_R2_POS: begin
        case (pc)
          4'd0:    u = mk(OP_ASQ, OP_TWELVE, 2'd0, 1'b0, 1'b1, CAP_NONE, 1'b0);
          4'd1:    u = mk(OP_ASQ, OP_Y,      2'd3, 1'b1, 1'b1, CAP_NONE, 1'b1);
          default: ;
        endcase
      end
      default: ;
    endcase
    return u;
  endfunction

endpackage

/* hdl/midpoint_ellipse_rasterizer.sv */
// Channel  Ports                                         Direction  Handshake
// in       in_command, in_semi_axis_x, in_semi_axis_y     input      in_valid / in_stall
// out      out_point_x, out_point_y, out_region,          output     out_valid / out_stall
//          out_last_of_group, out_finished
//
// One shared multiplier and one accumulator adder run a short microprogram; each
// multiply-accumulate operation passes through ST_MUL and then ST_ACC, and the four
// mirrored words leave from ST_EMIT, which holds while out_stall is high. Region-two steps
// after the first skip the compare and initialising programs that the first one runs.
// A step with nothing left to draw is accepted and gives no word.
// Reset leaves the block idle with nothing to draw; in_stall is high while busy.
module midpoint_ellipse_rasterizer #(
  parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [AXIS_BITS-1:0]        in_semi_axis_x,
  input  logic [AXIS_BITS-1:0]        in_semi_axis_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [AXIS_BITS:0]   out_point_x,
  output logic signed [AXIS_BITS:0]   out_point_y,
  output logic                        out_region,
  output logic                        out_last_of_group,
  output logic                        out_finished
);

  localparam int OPW = 2 * AXIS_BITS;
  localparam int PW  = 2 * OPW;
  localparam int DW  = 4 * AXIS_BITS + 4;

  mer_pkg::state_t state_r, state_nxt;
  mer_pkg::prog_t  prog_r, prog_nxt;
  logic [mer_pkg::PC_BITS-1:0] pc_r, pc_nxt;
  logic [AXIS_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt, ax_r, ax_nxt;
  logic [OPW-1:0] asq_r, asq_nxt, bsq_r, bsq_nxt, sq_r, sq_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic signed [DW-1:0] acc_r, acc_nxt, dec_r, dec_nxt, acc_sum, term;
  logic r2_r, r2_nxt, done_r, done_nxt, grp_r, grp_nxt;
  logic [1:0] q_r, q_nxt;
  logic [AXIS_BITS-1:0] x_inc, y_dec;
  logic [AXIS_BITS:0] px, py, nx, ny;
  mer_pkg::uop_t uop;
  logic [OPW-1:0] opa, opb;

  function automatic logic [OPW-1:0] operand(mer_pkg::opsel_t sel,
                                             logic [AXIS_BITS-1:0] ax,
                                             logic [AXIS_BITS-1:0] x,
                                             logic [AXIS_BITS-1:0] y,
                                             logic [OPW-1:0] asq,
                                             logic [OPW-1:0] bsq,
                                             logic [OPW-1:0] sq);
    logic [OPW-1:0] v;
    case (sel)
      mer_pkg::OP_AX:     v = OPW'(ax);
      mer_pkg::OP_X:      v = OPW'(x);
      mer_pkg::OP_Y:      v = OPW'(y);
      mer_pkg::OP_ASQ:    v = asq;
      mer_pkg::OP_BSQ:    v = bsq;
      mer_pkg::OP_SQ:     v = sq;
      mer_pkg::OP_ONE:    v = OPW'(1);
      mer_pkg::OP_TWELVE: v = OPW'(12);
      default:            v = '0;
    endcase
    return v;
  endfunction

  assign uop = mer_pkg::uop_rom(prog_r, pc_r);
  assign opa = operand(uop.sel_a, ax_r, cur_x_r, cur_y_r, asq_r, bsq_r, sq_r);
  assign opb = operand(uop.sel_b, ax_r, cur_x_r, cur_y_r, asq_r, bsq_r, sq_r);

  assign term    = $signed(DW'(prod_r) << uop.shift);
  assign acc_sum = uop.sub ? acc_r - term : acc_r + term;
  assign x_inc   = cur_x_r + {{(AXIS_BITS-1){1'b0}}, 1'b1};
  assign y_dec   = cur_y_r - {{(AXIS_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    state_nxt = state_r;
    prog_nxt  = prog_r;
    pc_nxt    = pc_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    ax_nxt    = ax_r;
    asq_nxt   = asq_r;
    bsq_nxt   = bsq_r;
    sq_nxt    = sq_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    dec_nxt   = dec_r;
    r2_nxt    = r2_r;
    done_nxt  = done_r;
    grp_nxt   = grp_r;
    q_nxt     = q_r;
    case (state_r)
      mer_pkg::ST_IDLE: begin
        if (in_valid) begin
          pc_nxt = '0;
          if (in_command == mer_pkg::CMD_START) begin
            ax_nxt    = in_semi_axis_x;
            cur_x_nxt = '0;
            cur_y_nxt = in_semi_axis_y;
            acc_nxt   = '0;
            r2_nxt    = 1'b0;
            prog_nxt  = mer_pkg::PR_START;
            state_nxt = mer_pkg::ST_MUL;
          end else if (!done_r) begin
            state_nxt = mer_pkg::ST_MUL;
            if (r2_r) begin
              acc_nxt  = dec_r;
              prog_nxt = dec_r[DW-1] ? mer_pkg::PR_R2_NEG : mer_pkg::PR_R2_POS;
            end else begin
              acc_nxt  = '0;
              prog_nxt = mer_pkg::PR_CMP;
            end
          end
        end
      end
      mer_pkg::ST_MUL: begin
        prod_nxt  = PW'(opa) * PW'(opb);
        state_nxt = mer_pkg::ST_ACC;
      end
      mer_pkg::ST_ACC: begin
        if (uop.acc_en) begin
          acc_nxt = acc_sum;
        end
        case (uop.cap)
          mer_pkg::CAP_ASQ: asq_nxt = prod_r[OPW-1:0];
          mer_pkg::CAP_BSQ: bsq_nxt = prod_r[OPW-1:0];
          mer_pkg::CAP_SQ:  sq_nxt  = prod_r[OPW-1:0];
          default: ;
        endcase
        if (!uop.last) begin
          pc_nxt    = pc_r + {{(mer_pkg::PC_BITS-1){1'b0}}, 1'b1};
          state_nxt = mer_pkg::ST_MUL;
        end else begin
          pc_nxt = '0;
          q_nxt  = '0;
          case (prog_r)
            mer_pkg::PR_START: begin
              dec_nxt   = acc_sum;
              done_nxt  = (cur_y_r == '0);
              grp_nxt   = 1'b0;
              state_nxt = mer_pkg::ST_EMIT;
            end
            mer_pkg::PR_CMP: begin
              state_nxt = mer_pkg::ST_MUL;
              if (!acc_sum[DW-1] && acc_sum != '0) begin
                acc_nxt  = dec_r;
                prog_nxt = dec_r[DW-1] ? mer_pkg::PR_R1_NEG : mer_pkg::PR_R1_POS;
              end else begin
                acc_nxt  = '0;
                r2_nxt   = 1'b1;
                prog_nxt = mer_pkg::PR_R2_INIT;
              end
            end
            mer_pkg::PR_R2_INIT: begin
              state_nxt = mer_pkg::ST_MUL;
              prog_nxt  = acc_sum[DW-1] ? mer_pkg::PR_R2_NEG : mer_pkg::PR_R2_POS;
            end
            mer_pkg::PR_R1_NEG: begin
              dec_nxt   = acc_sum;
              cur_x_nxt = x_inc;
              done_nxt  = (cur_y_r == '0);
              grp_nxt   = 1'b0;
              state_nxt = mer_pkg::ST_EMIT;
            end
            mer_pkg::PR_R1_POS: begin
              dec_nxt   = acc_sum;
              cur_x_nxt = x_inc;
              cur_y_nxt = y_dec;
              done_nxt  = (y_dec == '0);
              grp_nxt   = 1'b0;
              state_nxt = mer_pkg::ST_EMIT;
            end
            mer_pkg::PR_R2_NEG: begin
              dec_nxt   = acc_sum;
              cur_x_nxt = x_inc;
              cur_y_nxt = y_dec;
              done_nxt  = (y_dec == '0);
              grp_nxt   = 1'b1;
              state_nxt = mer_pkg::ST_EMIT;
            end
            mer_pkg::PR_R2_POS: begin
              dec_nxt   = acc_sum;
              cur_y_nxt = y_dec;
              done_nxt  = (y_dec == '0);
              grp_nxt   = 1'b1;
              state_nxt = mer_pkg::ST_EMIT;
            end
            default: state_nxt = mer_pkg::ST_IDLE;
          endcase
        end
      end
      mer_pkg::ST_EMIT: begin
        if (!out_stall) begin
          q_nxt = q_r + 2'd1;
          if (q_r == 2'd3) begin
            state_nxt = mer_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = mer_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mer_pkg::ST_IDLE;
      prog_r  <= mer_pkg::PR_START;
      pc_r    <= '0;
      q_r     <= '0;
      cur_x_r <= '0;
      cur_y_r <= '0;
      asq_r   <= '0;
      bsq_r   <= '0;
      dec_r   <= '0;
      r2_r    <= 1'b0;
      done_r  <= 1'b1;
      grp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prog_r  <= prog_nxt;
      pc_r    <= pc_nxt;
      q_r     <= q_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      asq_r   <= asq_nxt;
      bsq_r   <= bsq_nxt;
      dec_r   <= dec_nxt;
      r2_r    <= r2_nxt;
      done_r  <= done_nxt;
      grp_r   <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r   <= ax_nxt;
    sq_r   <= sq_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // Word order within a group: (x,y), (x,-y), (-x,-y), (-x,y).
  assign px = {1'b0, cur_x_r};
  assign py = {1'b0, cur_y_r};
  assign nx = ~px + {{AXIS_BITS{1'b0}}, 1'b1};
  assign ny = ~py + {{AXIS_BITS{1'b0}}, 1'b1};

  assign in_stall          = (state_r != mer_pkg::ST_IDLE);
  assign out_valid         = (state_r == mer_pkg::ST_EMIT);
  assign out_point_x       = (q_r == 2'd2 || q_r == 2'd3) ? nx : px;
  assign out_point_y       = (q_r == 2'd1 || q_r == 2'd2) ? ny : py;
  assign out_region        = grp_r;
  assign out_last_of_group = (q_r == 2'd3);
  assign out_finished      = done_r;

endmodule

/* tb/tb_midpoint_ellipse_rasterizer.sv */
module tb_midpoint_ellipse_rasterizer;

  localparam int AXIS_BITS = mer_pkg::AXIS_BITS_DEF;
  localparam int RANDOM_ITEMS = 70;

  typedef struct {
    mer_pkg::cmd_t          command;
    logic [AXIS_BITS-1:0]   axis_x;
    logic [AXIS_BITS-1:0]   axis_y;
  } raster_cmd_t;

  typedef struct {
    logic signed [AXIS_BITS:0] x;
    logic signed [AXIS_BITS:0] y;
    logic                      region;
    logic                      last_of_group;
    logic                      finished;
  } point_t;

  typedef enum {
    HOLD_NONE,
    HOLD_LIGHT,
    HOLD_HEAVY,
    HOLD_PERIODIC
  } hold_mode_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_command;
  logic [AXIS_BITS-1:0]      in_semi_axis_x;
  logic [AXIS_BITS-1:0]      in_semi_axis_y;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [AXIS_BITS:0] out_point_x;
  logic signed [AXIS_BITS:0] out_point_y;
  logic                      out_region;
  logic                      out_last_of_group;
  logic                      out_finished;

  raster_cmd_t pending_commands[$];
  point_t      expected_points[$];

  // Shadow copy of the rasterizer state.
  logic [AXIS_BITS-1:0] pos_x;
  logic [AXIS_BITS-1:0] pos_y;
  logic [63:0]          dvar;
  logic [63:0]          asq;
  logic [63:0]          bsq;
  bit                   in_region_two;
  bit                   drawn_out;

  bit         in_taken;
  int         burst_left;
  int         gap_left;
  hold_mode_t hold_mode;
  int         hold_left;
  int         error_count;
  int         commands_accepted;
  int         starts_accepted;
  int         points_checked;
  int         region_two_points;
  int         finished_groups;

  midpoint_ellipse_rasterizer #(
    .AXIS_BITS(AXIS_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_semi_axis_x   (in_semi_axis_x),
    .in_semi_axis_y   (in_semi_axis_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_region       (out_region),
    .out_last_of_group(out_last_of_group),
    .out_finished     (out_finished)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic push_mirrored_points(input bit zone, input bit fin);
    point_t                    p;
    logic signed [AXIS_BITS:0] sx;
    logic signed [AXIS_BITS:0] sy;
    sx = {1'b0, pos_x};
    sy = {1'b0, pos_y};
    for (int k = 0; k < 4; k++) begin
      p.x = (k < 2) ? sx : -sx;
      p.y = (k == 0 || k == 3) ? sy : -sy;
      p.region = zone;
      p.last_of_group = (k == 3);
      p.finished = fin;
      expected_points.push_back(p);
    end
  endtask

  task automatic predict_ellipse_points(input mer_pkg::cmd_t cmd,
                                        input logic [AXIS_BITS-1:0] ax,
                                        input logic [AXIS_BITS-1:0] ay);
    logic [63:0] px;
    logic [63:0] py;
    bit          zone;
    if (cmd == mer_pkg::CMD_START) begin
      px = 64'(ax);
      py = 64'(ay);
      asq = px * px;
      bsq = py * py;
      pos_x = '0;
      pos_y = ay;
      dvar = 4 * bsq - 4 * asq * py + asq;
      in_region_two = 1'b0;
      drawn_out = (ay == 0);
      push_mirrored_points(1'b0, drawn_out);
    end else if (!drawn_out) begin
      px = 64'(pos_x);
      py = 64'(pos_y);
      if (!in_region_two && asq * py > bsq * px) begin
        if (dvar[63]) begin
          dvar = dvar + 8 * bsq * px + 12 * bsq;
        end else begin
          dvar = dvar + 8 * bsq * px - 8 * asq * py + 8 * asq + 12 * bsq;
          py = py - 1;
        end
        px = px + 1;
        zone = 1'b0;
      end else begin
        if (!in_region_two) begin
          in_region_two = 1'b1;
          dvar = 4 * bsq * px * px + 4 * bsq * px + 4 * asq * py * py
               - 8 * asq * py + 4 * asq + bsq - 4 * asq * bsq;
        end
        if (dvar[63]) begin
          dvar = dvar + 8 * bsq * px - 8 * asq * py + 12 * asq + 8 * bsq;
          px = px + 1;
        end else begin
          dvar = dvar + 12 * asq - 8 * asq * py;
        end
        py = py - 1;
        zone = 1'b1;
      end
      pos_x = px[AXIS_BITS-1:0];
      pos_y = py[AXIS_BITS-1:0];
      if (pos_y == 0) begin
        drawn_out = 1'b1;
      end
      push_mirrored_points(zone, drawn_out);
    end
  endtask

  task automatic queue_start(input int ax, input int ay);
    raster_cmd_t c;
    c.command = mer_pkg::CMD_START;
    c.axis_x = AXIS_BITS'(ax);
    c.axis_y = AXIS_BITS'(ay);
    pending_commands.push_back(c);
  endtask

  task automatic queue_steps(input int n);
    raster_cmd_t c;
    for (int i = 0; i < n; i++) begin
      c.command = mer_pkg::CMD_STEP;
      c.axis_x = AXIS_BITS'($urandom);
      c.axis_y = AXIS_BITS'($urandom);
      pending_commands.push_back(c);
    end
  endtask

  always @(negedge clk) begin
    raster_cmd_t c;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0 || pending_commands.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end
      end else begin
        c = pending_commands.pop_front();
        in_valid <= 1'b1;
        in_command <= c.command;
        in_semi_axis_x <= c.axis_x;
        in_semi_axis_y <= c.axis_y;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left == 0) begin
      hold_mode = hold_mode_t'($urandom_range(0, 3));
      hold_left = $urandom_range(8, 40);
    end
    hold_left--;
    case (hold_mode)
      HOLD_NONE:  out_stall <= 1'b0;
      HOLD_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      HOLD_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ((hold_left % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    point_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      predict_ellipse_points(mer_pkg::cmd_t'(in_command), in_semi_axis_x, in_semi_axis_y);
      commands_accepted++;
      if (in_command == mer_pkg::CMD_START) begin
        starts_accepted++;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected word: x %0d y %0d", out_point_x, out_point_y);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (out_region === 1'b1) begin
          region_two_points++;
        end
        if (out_last_of_group === 1'b1 && out_finished === 1'b1) begin
          finished_groups++;
        end
        if (out_point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, out_point_x);
          error_count++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, out_point_y);
          error_count++;
        end
        if (out_region !== want.region) begin
          $error("region: expected %0d, got %0d", want.region, out_region);
          error_count++;
        end
        if (out_last_of_group !== want.last_of_group) begin
          $error("last_of_group: expected %0d, got %0d", want.last_of_group,
                 out_last_of_group);
          error_count++;
        end
        if (out_finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, out_finished);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d words still expected", expected_points.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    int kind;
    int ax;
    int ay;
    int n;
    int random_drawing;
    int total_commands;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = mer_pkg::CMD_STEP;
    in_semi_axis_x = '0;
    in_semi_axis_y = '0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    hold_mode = HOLD_NONE;
    error_count = 0;
    commands_accepted = 0;
    starts_accepted = 0;
    points_checked = 0;
    region_two_points = 0;
    finished_groups = 0;
    pos_x = '0;
    pos_y = '0;
    dvar = '0;
    asq = '0;
    bsq = '0;
    in_region_two = 1'b0;
    drawn_out = 1'b1;

    // A step straight after reset has nothing to draw.
    queue_steps(1);
    // Both axes zero: a single finished group at the origin.
    queue_start(0, 0);
    queue_steps(1);
    // Zero horizontal axis walks down x = 0 in region two, then one extra step.
    queue_start(0, 3);
    queue_steps(4);
    // Zero vertical axis with the widest horizontal axis finishes at once.
    queue_start(1023, 0);
    queue_start(1023, 1023);
    queue_steps(2);
    // A thin tall ellipse reaches region two with the largest products.
    queue_start(1, 1023);
    queue_steps(3);
    queue_start(1023, 1);
    queue_steps(2);
    // A new start follows an ellipse whose steps have just drawn it out.
    queue_start(3, 2);
    queue_steps(3);
    queue_start(5, 4);
    queue_steps(1);

    random_drawing = 0;
    while (random_drawing < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        ax = $urandom_range(0, 10);
        ay = $urandom_range(0, 10);
        queue_start(ax, ay);
        queue_steps(ax + ay + $urandom_range(0, 2));
        random_drawing += 1 + ax + ay;
      end else if (kind == 7) begin
        n = $urandom_range(0, 3);
        queue_start($urandom_range(0, 1023), $urandom_range(0, 1023));
        queue_steps(n);
        random_drawing += 1 + n;
      end else if (kind == 8) begin
        queue_steps($urandom_range(1, 3));
      end else begin
        ax = $urandom_range(0, 10);
        ay = $urandom_range(0, 10);
        n = $urandom_range(0, ax + ay);
        queue_start(ax, ay);
        queue_steps(n);
        random_drawing += 1 + n;
      end
    end
    total_commands = pending_commands.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (commands_accepted < total_commands) @(negedge clk);
    while (expected_points.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);

    $display("Drove %0d commands including %0d starts; checked %0d points,", commands_accepted,
             starts_accepted, points_checked);
    $display("%0d of them in region two, and %0d completed quadrants.", region_two_points,
             finished_groups);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
